### rtl/core/mrss_pkg.sv
// shared types, constants and register codes of the row-sum sorter
package mrss_pkg;

	localparam int MAX_ROWS_DEF = 8;
	localparam int MAX_COLS_DEF = 8;

	localparam int VAL_W     = 16;
	localparam int CNT_W     = 4;
	localparam int CFG_IDX_W = 1;

	localparam int JOBQ_DEPTH = 2;
	localparam int OUTQ_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

	localparam logic [CNT_W-1:0] COUNT_RESET = 4'd8;

	// counts in use, already clamped to their legal range
	typedef struct packed {
		logic [CNT_W-1:0] rows;
		logic [CNT_W-1:0] cols;
	} cfg_t;

	// one result beat
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             row_end;
		logic             matrix_end;
	} beat_t;

endpackage

### rtl/core/mrss_fifo.sv
// small first-in first-out queue with occupancy count
module mrss_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic [CNT_W-1:0] count
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	always_comb begin
		full    = (count_q == CNT_W'(DEPTH));
		empty   = (count_q == '0);
		do_push = push & ~full;
		do_pop  = pop & ~empty;
		rdata   = mem_q[rd_ptr_q];
		count   = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### rtl/core/mrss_front.sv
// front part: element loading, row sums and the exchange sort of row order
module mrss_front #(
	parameter int MAX_ROWS = mrss_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = mrss_pkg::MAX_COLS_DEF,
	localparam int ROW_W  = $clog2(MAX_ROWS),
	localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS),
	localparam int JOB_W  = ROW_W + 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mrss_pkg::cfg_t                      cfg,
	input  logic                                cfg_we,
	input  logic                                push,
	output logic                                full,
	input  logic signed [mrss_pkg::VAL_W-1:0]   element_value,
	output logic                                store_we,
	output logic [ADDR_W-1:0]                   store_addr,
	output logic [mrss_pkg::VAL_W-1:0]          store_wdata,
	output logic                                job_push,
	output logic [JOB_W-1:0]                    job_data,
	input  logic                                job_full,
	input  logic                                back_idle
);

	import mrss_pkg::*;

	localparam int SUM_W = VAL_W + $clog2(MAX_COLS);

	typedef enum logic [5:0] {
		ST_LOAD  = 6'b000001,
		ST_SETUP = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_WRBK  = 6'b001000,
		ST_TAIL  = 6'b010000,
		ST_WAIT  = 6'b100000
	} state_t;

	state_t                   state_q;
	logic [ROW_W-1:0]         r_q;
	logic [COL_W-1:0]         c_q;
	logic [ROW_W-1:0]         i_q;
	logic [ROW_W-1:0]         j_q;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]  cur_sum_q;
	logic [ROW_W-1:0]         cur_idx_q;
	// sums and row numbers held by sorted position
	logic signed [SUM_W-1:0]  psum_q [MAX_ROWS];
	logic [ROW_W-1:0]         porder_q [MAX_ROWS];

	logic                     accept;
	logic                     col_last;
	logic                     row_last;
	logic                     i_last;
	logic                     j_last;
	logic signed [SUM_W-1:0]  val_ext;
	logic signed [SUM_W-1:0]  acc_next;
	logic [ROW_W-1:0]         rd_idx;
	logic signed [SUM_W-1:0]  rd_sum;
	logic [ROW_W-1:0]         rd_ord;
	logic                     swap;

	always_comb begin
		full     = (state_q != ST_LOAD);
		accept   = push & ~full;
		col_last = (CNT_W'(c_q) == cfg.cols - CNT_W'(1));
		row_last = (CNT_W'(r_q) == cfg.rows - CNT_W'(1));
		i_last   = (CNT_W'(i_q) == cfg.rows - CNT_W'(2));
		j_last   = (CNT_W'(j_q) == cfg.rows - CNT_W'(1));
		val_ext  = SUM_W'(element_value);
		acc_next = (c_q == '0) ? val_ext : acc_q + val_ext;

		// single read port into the position arrays
		case (state_q)
			ST_SETUP: rd_idx = i_q;
			ST_SCAN:  rd_idx = j_q;
			default:  rd_idx = ROW_W'(cfg.rows - CNT_W'(1));
		endcase
		rd_sum = psum_q[rd_idx];
		rd_ord = porder_q[rd_idx];
		swap   = (state_q == ST_SCAN) && (cur_sum_q > rd_sum);

		store_we    = accept;
		store_addr  = ADDR_W'(r_q * MAX_COLS) + ADDR_W'(c_q);
		store_wdata = element_value;

		job_push = ((state_q == ST_WRBK) || (state_q == ST_TAIL)) && !job_full;
		job_data = (state_q == ST_WRBK) ? {1'b0, cur_idx_q} : {1'b1, rd_ord};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			r_q     <= '0;
			c_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			for (int k = 0; k < MAX_ROWS; k++) begin
				porder_q[k] <= ROW_W'(k);
			end
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (cfg_we) begin
						r_q <= '0;
						c_q <= '0;
					end else if (accept) begin
						if (col_last) begin
							c_q <= '0;
							if (row_last) begin
								r_q     <= '0;
								i_q     <= '0;
								state_q <= (cfg.rows == CNT_W'(1)) ? ST_TAIL : ST_SETUP;
							end else begin
								r_q <= r_q + ROW_W'(1);
							end
						end else begin
							c_q <= c_q + COL_W'(1);
						end
					end
				end
				ST_SETUP: begin
					j_q     <= i_q + ROW_W'(1);
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (swap) begin
						porder_q[j_q] <= cur_idx_q;
					end
					if (j_last) begin
						state_q <= ST_WRBK;
					end else begin
						j_q <= j_q + ROW_W'(1);
					end
				end
				ST_WRBK: begin
					if (!job_full) begin
						porder_q[i_q] <= cur_idx_q;
						if (i_last) begin
							state_q <= ST_TAIL;
						end else begin
							i_q     <= i_q + ROW_W'(1);
							state_q <= ST_SETUP;
						end
					end
				end
				ST_TAIL: begin
					if (!job_full) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (back_idle) begin
						state_q <= ST_LOAD;
						for (int k = 0; k < MAX_ROWS; k++) begin
							porder_q[k] <= ROW_W'(k);
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				if (accept && !cfg_we) begin
					acc_q <= acc_next;
					if (col_last) begin
						psum_q[r_q] <= acc_next;
					end
				end
			end
			ST_SETUP: begin
				cur_sum_q <= rd_sum;
				cur_idx_q <= rd_ord;
			end
			ST_SCAN: begin
				if (swap) begin
					psum_q[j_q] <= cur_sum_q;
					cur_sum_q   <= rd_sum;
					cur_idx_q   <= rd_ord;
				end
			end
			ST_WRBK: begin
				if (!job_full) begin
					psum_q[i_q] <= cur_sum_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/core/mrss_back.sv
// back part: element store, row read-out and result queue
module mrss_back #(
	parameter int MAX_ROWS = mrss_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = mrss_pkg::MAX_COLS_DEF,
	localparam int ROW_W  = $clog2(MAX_ROWS),
	localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS),
	localparam int JOB_W  = ROW_W + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mrss_pkg::cfg_t               cfg,
	input  logic                         store_we,
	input  logic [ADDR_W-1:0]            store_addr,
	input  logic [mrss_pkg::VAL_W-1:0]   store_wdata,
	input  logic                         job_empty,
	input  logic [JOB_W-1:0]             job_data,
	output logic                         job_pop,
	output logic                         busy,
	output logic                         empty,
	input  logic                         pop,
	output mrss_pkg::beat_t              beat
);

	import mrss_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int OQ_CW = $clog2(OUTQ_DEPTH + 1);

	logic [VAL_W-1:0] mem_q [DEPTH];

	logic             busy_q;
	logic [ROW_W-1:0] src_q;
	logic             last_q;
	logic [COL_W-1:0] col_q;

	logic             v_s1;
	beat_t            beat_s1;

	logic             col_last;
	logic             issue;
	logic [ADDR_W-1:0] rd_addr;
	logic [OQ_CW-1:0] oq_count;
	logic             oq_full;

	always_comb begin
		col_last = (CNT_W'(col_q) == cfg.cols - CNT_W'(1));
		// room left once the beat in flight has landed
		issue    = busy_q && ((OQ_CW + 1)'(oq_count) + (OQ_CW + 1)'(v_s1)
			< (OQ_CW + 1)'(OUTQ_DEPTH));
		job_pop  = !job_empty && (!busy_q || (issue && col_last));
		rd_addr  = ADDR_W'(src_q * MAX_COLS) + ADDR_W'(col_q);
		busy     = busy_q;
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			mem_q[store_addr] <= store_wdata;
		end
		if (issue) begin
			beat_s1.value      <= mem_q[rd_addr];
			beat_s1.row_end    <= col_last;
			beat_s1.matrix_end <= col_last && last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			src_q  <= '0;
			last_q <= 1'b0;
			col_q  <= '0;
			v_s1   <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (job_pop) begin
				busy_q <= 1'b1;
				src_q  <= job_data[ROW_W-1:0];
				last_q <= job_data[JOB_W-1];
				col_q  <= '0;
			end else if (issue) begin
				if (col_last) begin
					busy_q <= 1'b0;
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	mrss_fifo #(
		.WIDTH ($bits(beat_t)),
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (v_s1),
		.wdata  (beat_s1),
		.full   (oq_full),
		.pop    (pop),
		.rdata  (beat),
		.empty  (empty),
		.count  (oq_count)
	);

	// credit check above keeps the queue from overflowing
	logic unused_full;
	assign unused_full = oq_full;

endmodule

### rtl/core/matrix_row_sum_sorter.sv
// top level of the matrix row-sum sorter
// The block takes a matrix of rows x cols signed Q8.8 elements in row-major
// order, one beat per cycle, and returns the same matrix with its rows in
// ascending order of their exact row sums; rows with equal sums keep the
// order an exchange sort over all position pairs leaves them in. Each result
// beat carries row_end on the last element of a row and matrix_end on the last
// element of the matrix. Loading runs at one element per cycle while full is
// low. After the last element a sequencer walks the position pairs with one
// compare per cycle: per position i it takes a setup step, a compare with each
// later position and a write-back step that waits on a full job queue. Every
// finished position is handed through a two-entry job queue to the read-out
// side, which reads the element store into a four-beat result queue at one
// element per cycle while that queue has room, so emission overlaps the rest
// of the sort. full stays high from the last element until the last element
// of the sorted matrix has been read from the store; the next matrix then
// loads at once. Row and column counts are written through cfg_we/cfg_index/
// cfg_data; zero reads as one and values above the maximum as the maximum. A
// write restarts any partly loaded matrix.
module matrix_row_sum_sorter #(
	parameter int MAX_ROWS = mrss_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = mrss_pkg::MAX_COLS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [mrss_pkg::VAL_W-1:0]   element_value,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [mrss_pkg::VAL_W-1:0]   out_value,
	output logic                                row_end,
	output logic                                matrix_end,
	input  logic                                cfg_we,
	input  logic [mrss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mrss_pkg::CNT_W-1:0]          cfg_data
);

	import mrss_pkg::*;

	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);
	localparam int JOB_W  = ROW_W + 1;

	// raw register contents, clamped below
	logic [CNT_W-1:0] row_count_q;
	logic [CNT_W-1:0] col_count_q;
	cfg_t             cfg;

	// store write port, front to back
	logic              store_we;
	logic [ADDR_W-1:0] store_addr;
	logic [VAL_W-1:0]  store_wdata;

	// job queue between the sort and the read-out
	logic              job_push;
	logic [JOB_W-1:0]  job_wdata;
	logic              job_full;
	logic              job_pop;
	logic [JOB_W-1:0]  job_rdata;
	logic              job_empty;

	logic              back_busy;
	logic              back_idle;
	beat_t             beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= COUNT_RESET;
			col_count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROW_COUNT: row_count_q <= cfg_data;
				CFG_COL_COUNT: col_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		// zero counts as one, above the maximum saturates
		if (row_count_q == '0) begin
			cfg.rows = CNT_W'(1);
		end else if (row_count_q > CNT_W'(MAX_ROWS)) begin
			cfg.rows = CNT_W'(MAX_ROWS);
		end else begin
			cfg.rows = row_count_q;
		end
		if (col_count_q == '0) begin
			cfg.cols = CNT_W'(1);
		end else if (col_count_q > CNT_W'(MAX_COLS)) begin
			cfg.cols = CNT_W'(MAX_COLS);
		end else begin
			cfg.cols = col_count_q;
		end
		// the store may be overwritten once every read of it is issued
		back_idle  = job_empty & ~back_busy;
		out_value  = beat.value;
		row_end    = beat.row_end;
		matrix_end = beat.matrix_end;
	end

	mrss_front #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cfg_we        (cfg_we),
		.push          (push),
		.full          (full),
		.element_value (element_value),
		.store_we      (store_we),
		.store_addr    (store_addr),
		.store_wdata   (store_wdata),
		.job_push      (job_push),
		.job_data      (job_wdata),
		.job_full      (job_full),
		.back_idle     (back_idle)
	);

	mrss_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (JOBQ_DEPTH)
	) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_wdata),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_rdata),
		.empty  (job_empty),
		.count  ()
	);

	mrss_back #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.store_we    (store_we),
		.store_addr  (store_addr),
		.store_wdata (store_wdata),
		.job_empty   (job_empty),
		.job_data    (job_rdata),
		.job_pop     (job_pop),
		.busy        (back_busy),
		.empty       (empty),
		.pop         (pop),
		.beat        (beat)
	);

	// the last beat of a matrix always closes a row
	a_mend_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && matrix_end) |-> row_end)
		else $error("matrix end without row end");

	// the sort never pushes a job into a full queue
	a_job_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("job pushed into full queue");

	// read-out starts only on a job taken from the queue
	a_busy_from_job: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(back_busy) |-> $past(job_pop))
		else $error("read-out started without a job");

	// loading only while no read of the store is pending
	a_load_safe: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> (job_empty && !back_busy))
		else $error("loading while store reads pending");

endmodule

### sim/mrss_checker.sv
// checker for the row-sum sorter: predicts each sorted matrix and compares result beats
`timescale 1ns / 1ps
module mrss_checker #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic                              full,
	input  logic signed [mrss_pkg::VAL_W-1:0] element_value,
	input  logic                              empty,
	input  logic                              pop,
	input  logic signed [mrss_pkg::VAL_W-1:0] out_value,
	input  logic                              row_end,
	input  logic                              matrix_end,
	input  logic                              cfg_we,
	input  logic [mrss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mrss_pkg::CNT_W-1:0]        cfg_data,
	output int                                fail_count,
	output int                                pending
);
	import mrss_pkg::*;

	localparam int SUM_W = VAL_W + 3;

	logic signed [VAL_W-1:0] elem_mem [MAX_ROWS*MAX_COLS];
	logic signed [SUM_W-1:0] row_total [MAX_ROWS];
	int unsigned             row_rank [MAX_ROWS];
	int unsigned             fill_pos;
	logic [CNT_W-1:0]        rows_reg;
	logic [CNT_W-1:0]        cols_reg;
	beat_t                   sorted_beats [$];

	function automatic int unsigned clamp_count(logic [CNT_W-1:0] v, int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return 32'(v);
	endfunction

	task automatic restart_fill();
		fill_pos = 0;
		for (int r = 0; r < MAX_ROWS; r++) begin
			row_total[r] = '0;
			row_rank[r] = r;
		end
	endtask

	// load one element; the completing element sorts and queues the whole matrix
	task automatic absorb_element(logic signed [VAL_W-1:0] v);
		int unsigned rows, cols, total, r, c, src, k, tmp;
		beat_t b;
		rows = clamp_count(rows_reg, MAX_ROWS);
		cols = clamp_count(cols_reg, MAX_COLS);
		total = rows * cols;
		if (fill_pos >= total)
			restart_fill();
		r = fill_pos / cols;
		c = fill_pos % cols;
		elem_mem[r*MAX_COLS + c] = v;
		row_total[r] = row_total[r] + v;
		fill_pos++;
		if (fill_pos == total) begin
			// exchange sort, strict compare keeps equal sums where the pass leaves them
			for (int i = 0; i + 1 < rows; i++) begin
				for (int j = i + 1; j < rows; j++) begin
					if (row_total[row_rank[i]] > row_total[row_rank[j]]) begin
						tmp = row_rank[i];
						row_rank[i] = row_rank[j];
						row_rank[j] = tmp;
					end
				end
			end
			k = 0;
			for (int i = 0; i < rows; i++) begin
				src = row_rank[i];
				for (int j = 0; j < cols; j++) begin
					b.value = elem_mem[src*MAX_COLS + j];
					b.row_end = (j + 1 == cols);
					b.matrix_end = (k + 1 == total);
					sorted_beats.push_back(b);
					k++;
				end
			end
			restart_fill();
		end
	endtask

	task automatic flag_beat(string what, beat_t want, beat_t got);
		fail_count++;
		if (fail_count <= 10)
			$display({"%0t sorted beat %s: want value %0d row_end %0b matrix_end %0b, ",
				"got value %0d row_end %0b matrix_end %0b"},
				$time, what, $signed(want.value), want.row_end, want.matrix_end,
				$signed(got.value), got.row_end, got.matrix_end);
	endtask

	always @(posedge clk or negedge arst_n) begin
		beat_t got;
		beat_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_ROWS*MAX_COLS; i++)
				elem_mem[i] = '0;
			rows_reg = COUNT_RESET;
			cols_reg = COUNT_RESET;
			restart_fill();
			sorted_beats.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// a register write drops any partly loaded matrix
			if (cfg_we) begin
				if (cfg_index == CFG_ROW_COUNT) begin
					rows_reg = cfg_data;
					restart_fill();
				end else if (cfg_index == CFG_COL_COUNT) begin
					cols_reg = cfg_data;
					restart_fill();
				end
			end
			if (push && !full)
				absorb_element(element_value);
			if (pop && !empty) begin
				got.value = out_value;
				got.row_end = row_end;
				got.matrix_end = matrix_end;
				if (sorted_beats.size() == 0) begin
					flag_beat("with nothing pending", '0, got);
				end else begin
					want = sorted_beats.pop_front();
					if (got.value !== want.value || got.row_end !== want.row_end ||
						got.matrix_end !== want.matrix_end)
						flag_beat("mismatch", want, got);
				end
			end
			pending = sorted_beats.size();
		end
	end

endmodule

### sim/matrix_row_sum_sorter_tb.sv
// testbench top for the row-sum sorter: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps
module matrix_row_sum_sorter_tb;
	import mrss_pkg::*;

	localparam int MAX_ROWS      = 8;
	localparam int MAX_COLS      = 8;
	localparam int ITEMS         = 220;
	// settle pause, long enough for a sort of 8 rows and a read-out of up to 64 elements
	localparam int SETTLE_CYCLES = 150;
	// longest quiet stretch: receiver hold-off plus a settle pause and a full sort
	localparam int STALL_LIMIT   = 3000;

	logic                    clk;
	logic                    arst_n;
	logic                    push;
	logic                    full;
	logic signed [VAL_W-1:0] element_value;
	logic                    empty;
	logic                    pop;
	logic signed [VAL_W-1:0] out_value;
	logic                    row_end;
	logic                    matrix_end;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CNT_W-1:0]        cfg_data;
	int                      fail_count;
	int                      pending;

	// pacing controls shared between the sender, the receiver and the sequence
	bit steady_tx;
	bit steady_rx;
	int hold_req;
	int items_sent;

	matrix_row_sum_sorter #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.element_value(element_value),
		.empty(empty),
		.pop(pop),
		.out_value(out_value),
		.row_end(row_end),
		.matrix_end(matrix_end),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	mrss_checker #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.element_value(element_value),
		.empty(empty),
		.pop(pop),
		.out_value(out_value),
		.row_end(row_end),
		.matrix_end(matrix_end),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// result side: random stalls, a stall-free stretch, and a long counted hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (steady_rx) begin
				pop <= 1'b1;
			end else begin
				pop <= ($urandom_range(0, 99) >= 33);
			end
		end
	end

	// watchdog on cycles with no beat moving on either side
	initial begin
		int stalled;
		stalled = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				stalled = 0;
			else
				stalled++;
			if (stalled >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// zero reads as one, anything past the maximum as the maximum
	function automatic int eff_count(logic [CNT_W-1:0] v, int hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return int'(v);
	endfunction

	// offer one element; called at a falling edge, returns at the falling edge after acceptance
	task automatic send_element(logic signed [VAL_W-1:0] v);
		while (!steady_tx && $urandom_range(0, 99) < 33) begin
			push <= 1'b0;
			element_value <= VAL_W'($urandom);
			@(negedge clk);
		end
		push <= 1'b1;
		element_value <= v;
		do @(posedge clk); while (full);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// stop offering, wait for every predicted beat, then let the block settle
	task automatic drain_results();
		push <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// build a rows x cols matrix in one of several flavours and send its first count elements
	task automatic load_matrix(int rows, int cols, int count, int flavour);
		logic signed [VAL_W-1:0] tile [MAX_ROWS*MAX_COLS];
		int src;
		for (int r = 0; r < rows; r++) begin
			src = (r > 0 && $urandom_range(0, 1)) ? $urandom_range(0, r - 1) : r;
			for (int c = 0; c < cols; c++) begin
				case (flavour)
					0: tile[r*cols + c] = VAL_W'($urandom);
					// tiny values, so equal row sums are common
					1: tile[r*cols + c] = VAL_W'(int'($urandom_range(0, 4)) - 2);
					// extremes and values next to zero only
					2: case ($urandom_range(0, 4))
						0: tile[r*cols + c] = 16'sh8000;
						1: tile[r*cols + c] = 16'sh7fff;
						2: tile[r*cols + c] = 16'sh0000;
						3: tile[r*cols + c] = -16'sd1;
						default: tile[r*cols + c] = 16'sd1;
					endcase
					// copies of earlier rows give exact ties with real content
					default: tile[r*cols + c] = (src != r) ? tile[src*cols + c] :
						VAL_W'($urandom);
				endcase
			end
		end
		for (int i = 0; i < count; i++)
			send_element(tile[i]);
	endtask

	initial begin
		logic signed [VAL_W-1:0] dir_row [8];
		logic signed [VAL_W-1:0] dir_col [8];
		logic signed [VAL_W-1:0] dir_tie [6];
		logic [CNT_W-1:0] rd;
		logic [CNT_W-1:0] cd;
		int rows_eff;
		int cols_eff;
		int total;
		int mat_no;
		bit change;

		arst_n = 1'b0;
		push = 1'b0;
		element_value = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_ROW_COUNT;
		cfg_data = '0;
		steady_tx = 1'b0;
		steady_rx = 1'b0;
		hold_req = 0;
		items_sent = 0;
		dir_row = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd1, 16'sh0100, 16'shff00,
			16'sh5555};
		dir_col = '{16'sh7fff, 16'sh8000, 16'sd5, 16'sd5, -16'sd5, 16'sd0, 16'sh7fff, 16'sh8000};
		dir_tie = '{16'sd1, 16'sd2, 16'sd3, 16'sd3, 16'sd3, 16'sd0};

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// row count zero reads as one, column count fifteen saturates to eight
		write_reg(CFG_ROW_COUNT, 4'd0);
		write_reg(CFG_COL_COUNT, 4'd15);
		foreach (dir_row[i])
			send_element(dir_row[i]);
		drain_results();

		// eight one-element rows: full-scale sums, swaps and exact ties
		write_reg(CFG_ROW_COUNT, 4'd9);
		write_reg(CFG_COL_COUNT, 4'd0);
		foreach (dir_col[i])
			send_element(dir_col[i]);
		drain_results();

		// partly loaded 2x2 thrown away by a register write, then a 2x3 with equal sums
		write_reg(CFG_ROW_COUNT, 4'd2);
		write_reg(CFG_COL_COUNT, 4'd2);
		send_element(16'sd7);
		send_element(-16'sd7);
		drain_results();
		write_reg(CFG_COL_COUNT, 4'd3);
		foreach (dir_tie[i])
			send_element(dir_tie[i]);
		drain_results();

		// random matrices, mostly small, back to back while the shape stays the same
		rows_eff = 2;
		cols_eff = 3;
		rd = 4'd2;
		cd = 4'd3;
		mat_no = 0;
		while (items_sent < ITEMS) begin
			change = (mat_no == 0 || mat_no == 3 || (mat_no > 5 && $urandom_range(0, 99) < 40));
			if (change) begin
				drain_results();
				if (mat_no == 3) begin
					rd = 4'd4;
					cd = 4'd4;
				end else if ($urandom_range(0, 99) < 12) begin
					rd = 4'($urandom_range(8, 15));
					cd = 4'($urandom_range(8, 15));
				end else begin
					rd = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 4));
					cd = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 4));
				end
				write_reg(CFG_ROW_COUNT, rd);
				write_reg(CFG_COL_COUNT, cd);
				rows_eff = eff_count(rd, MAX_ROWS);
				cols_eff = eff_count(cd, MAX_COLS);
			end
			total = rows_eff * cols_eff;
			// a stretch with no idling on either side
			steady_tx = (mat_no >= 6 && mat_no < 10);
			steady_rx = steady_tx;
			// receiver holds off while matrices keep coming, so the block backs up
			if (mat_no == 3)
				hold_req = 400;
			if (mat_no > 5 && total > 1 && $urandom_range(0, 99) < 10) begin
				// broken load: cut short, then restarted by rewriting a count
				load_matrix(rows_eff, cols_eff, $urandom_range(1, total - 1),
					$urandom_range(0, 3));
				drain_results();
				write_reg(CFG_ROW_COUNT, rd);
			end else begin
				load_matrix(rows_eff, cols_eff, total, $urandom_range(0, 3));
			end
			mat_no++;
		end
		drain_results();

		if (fail_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### filelist.f
rtl/core/mrss_pkg.sv
rtl/core/mrss_fifo.sv
rtl/core/mrss_front.sv
rtl/core/mrss_back.sv
rtl/core/matrix_row_sum_sorter.sv
sim/mrss_checker.sv
sim/matrix_row_sum_sorter_tb.sv
